// ----- rtl/dynamic_fixed_point_alu_unit_assert.svh -----
// Assertion macros for the dynamic fixed-point ALU.
// Relies on clk and rst_n being in scope at the place of use.
`ifndef DYNAMIC_FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define DYNAMIC_FIXED_POINT_ALU_UNIT_ASSERT_SVH
// same-cycle implication
`define DFPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfpa check failed");
// next-cycle implication
`define DFPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfpa check failed");
`endif

// ----- rtl/dfpa_pkg.sv -----
// Shared constants, item type and helper functions for the dynamic fixed-point ALU.
// No dependencies.
package dfpa_pkg;

  localparam int WIDTH     = 32;
  localparam int DIV_STEPS = 63;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic        is_div;
    logic        neg;
    logic        dz;
    logic [6:0]  n;
    logic [63:0] q;     // value, or dividend magnitude / quotient on divide
    logic [31:0] rem;
    logic [31:0] dsor;
    logic [4:0]  na;
    logic [4:0]  ma;
  } item_t;

  // low WIDTH bits, sign-extended
  function automatic logic signed [31:0] sext_w(logic [31:0] x);
    logic signed [31:0] s;
    s = $signed(x) <<< (32 - WIDTH);
    return s >>> (32 - WIDTH);
  endfunction

  // two's complement bits needed, sign included
  function automatic logic [5:0] sig32(logic [31:0] x);
    logic [31:0] u;
    logic [5:0]  s;
    u = x[31] ? ~x : x;
    s = 6'd1;
    for (int i = 0; i < 32; i++) begin
      if (u[i]) s = 6'(i + 2);
    end
    return s;
  endfunction

  // one restoring-division step
  function automatic item_t div_step(item_t x);
    item_t      y;
    logic [32:0] sh;
    logic [32:0] diff;
    y = x;
    if (x.is_div) begin
      sh   = {x.rem, x.q[62]};
      diff = sh - {1'b0, x.dsor};
      if (sh >= {1'b0, x.dsor}) begin
        y.rem  = diff[31:0];
        y.q[62:0] = {x.q[61:0], 1'b1};
      end else begin
        y.rem  = sh[31:0];
        y.q[62:0] = {x.q[61:0], 1'b0};
      end
    end
    return y;
  endfunction

endpackage

// ----- rtl/dfpa_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on dfpa_pkg; items that are not divides pass through untouched.
module dfpa_div_pipe (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  dfpa_pkg::item_t in_item,
  output logic           out_vld,
  output dfpa_pkg::item_t out_item
);
  import dfpa_pkg::*;

  logic [DIV_STEPS-1:0] vld_r;
  item_t                stg_r [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DIV_STEPS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0] <= div_step(in_item);
      for (int k = 1; k < DIV_STEPS; k++) begin
        stg_r[k] <= div_step(stg_r[k-1]);
      end
    end
  end

  assign out_vld  = vld_r[DIV_STEPS-1];
  assign out_item = stg_r[DIV_STEPS-1];

endmodule

// ----- rtl/dynamic_fixed_point_alu_unit.sv -----
// Dynamic fixed-point ALU: add, subtract, multiply and divide on operands that
// each carry their own fraction count, result renormalised to the widest fit.
// One item per clock when not stalled; 3 operand stages, 63 divider stages and
// 5 renormalisation stages. The 63-step restoring divider sets the depth; all
// operations travel through it so results leave in order. A stall holds every
// stage. Depends on dfpa_pkg, dfpa_div_pipe and the assertion header.
module dynamic_fixed_point_alu_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_a_raw,
  input  logic [4:0]         in_a_frac_bits,
  input  logic [4:0]         in_a_int_bits,
  input  logic signed [31:0] in_b_raw,
  input  logic [4:0]         in_b_frac_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_raw,
  output logic [4:0]         out_result_frac_bits,
  output logic [4:0]         out_result_int_bits,
  output logic               out_div_by_zero,
  output logic               out_overflow
);
  import dfpa_pkg::*;
  `include "dynamic_fixed_point_alu_unit_assert.svh"

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage A: capture, significant bits of a
  logic               a_vld_r;
  logic [1:0]         a_op_r;
  logic signed [31:0] a_a_r, a_b_r;
  logic [4:0]         a_na_r, a_nb_r, a_ma_r;
  logic [5:0]         a_sig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (adv) a_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r  <= in_action;
      a_a_r   <= sext_w(in_a_raw);
      a_b_r   <= sext_w(in_b_raw);
      a_na_r  <= in_a_frac_bits;
      a_nb_r  <= in_b_frac_bits;
      a_ma_r  <= in_a_int_bits;
      a_sig_r <= sig32(sext_w(in_a_raw));
    end
  end

  // stage B: alignment, product, boosted numerator
  logic               b_vld_r;
  logic [1:0]         b_op_r;
  logic signed [63:0] b_q0_r, b_q1_r;
  logic [6:0]         b_n_r;
  logic signed [31:0] b_b_r;
  logic               b_dz_r;
  logic [4:0]         b_na_r, b_ma_r;

  logic [4:0]         nout;
  logic [5:0]         boost;
  logic signed [63:0] ea, eb, prod, q0_nxt;
  logic [6:0]         n_nxt;

  always_comb begin
    nout  = (a_na_r > a_nb_r) ? a_na_r : a_nb_r;
    boost = 6'd63 - a_sig_r;
    ea    = 64'(a_a_r);
    eb    = 64'(a_b_r);
    prod  = a_a_r * a_b_r;
    case (a_op_r)
      OP_MUL: begin
        q0_nxt = prod;
        n_nxt  = {2'b0, a_na_r} + {2'b0, a_nb_r};
      end
      OP_DIV: begin
        q0_nxt = ea <<< boost;
        n_nxt  = {2'b0, a_na_r} + {1'b0, boost} - {2'b0, a_nb_r};
      end
      default: begin
        q0_nxt = ea <<< (nout - a_na_r);
        n_nxt  = {2'b0, nout};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (adv) b_vld_r <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op_r <= a_op_r;
      b_q0_r <= q0_nxt;
      b_q1_r <= eb <<< (nout - a_nb_r);
      b_n_r  <= n_nxt;
      b_b_r  <= a_b_r;
      b_dz_r <= (a_b_r == 32'sd0);
      b_na_r <= a_na_r;
      b_ma_r <= a_ma_r;
    end
  end

  // stage C: add/sub, divider set-up
  logic  c_vld_r;
  item_t c_item_r, c_nxt;
  logic [63:0] mag;

  always_comb begin
    mag        = b_q0_r[63] ? 64'(-b_q0_r) : 64'(b_q0_r);
    c_nxt      = '0;
    c_nxt.n    = b_n_r;
    c_nxt.na   = b_na_r;
    c_nxt.ma   = b_ma_r;
    c_nxt.dz   = (b_op_r == OP_DIV) && b_dz_r;
    c_nxt.is_div = (b_op_r == OP_DIV);
    c_nxt.neg  = b_q0_r[63] ^ b_b_r[31];
    c_nxt.dsor = b_b_r[31] ? 32'(-b_b_r) : 32'(b_b_r);
    case (b_op_r)
      OP_ADD:  c_nxt.q = b_q0_r + b_q1_r;
      OP_SUB:  c_nxt.q = b_q0_r - b_q1_r;
      OP_MUL:  c_nxt.q = b_q0_r;
      OP_DIV:  c_nxt.q = {1'b0, mag[62:0]};
      default: c_nxt.q = b_q0_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (adv) c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) c_item_r <= c_nxt;
  end

  logic  dv_vld;
  item_t dv_item;

  dfpa_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (c_vld_r),
    .in_item  (c_item_r),
    .out_vld  (dv_vld),
    .out_item (dv_item)
  );

  // stage D: quotient sign
  logic               d_vld_r, d_dz_r;
  logic signed [63:0] d_q_r;
  logic [6:0]         d_n_r;
  logic [4:0]         d_na_r, d_ma_r;
  logic [63:0]        quot;

  assign quot = {1'b0, dv_item.q[62:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (adv) d_vld_r <= dv_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dv_item.is_div) d_q_r <= dv_item.neg ? $signed(-quot) : $signed(quot);
      else d_q_r <= $signed(dv_item.q);
      d_n_r  <= dv_item.n;
      d_dz_r <= dv_item.dz;
      d_na_r <= dv_item.na;
      d_ma_r <= dv_item.ma;
    end
  end

  // P1: leading-sign search per 16-bit chunk
  logic               p1_vld_r, p1_dz_r, p1_zero_r;
  logic signed [63:0] p1_q_r;
  logic [6:0]         p1_n_r;
  logic [4:0]         p1_na_r, p1_ma_r;
  logic [3:0]         p1_hit_r;
  logic [3:0]         p1_idx_r [4];
  logic [63:0]        u;
  logic [3:0]         hit;
  logic [3:0]         idx [4];

  always_comb begin
    u = d_q_r[63] ? ~d_q_r : d_q_r;
    for (int c = 0; c < 4; c++) begin
      hit[c] = |u[16*c +: 16];
      idx[c] = 4'd0;
      for (int i = 0; i < 16; i++) begin
        if (u[16*c + i]) idx[c] = 4'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p1_vld_r <= 1'b0;
    else if (adv) p1_vld_r <= d_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_q_r    <= d_q_r;
      p1_n_r    <= d_n_r;
      p1_dz_r   <= d_dz_r;
      p1_na_r   <= d_na_r;
      p1_ma_r   <= d_ma_r;
      p1_zero_r <= (d_q_r == 64'sd0);
      p1_hit_r  <= hit;
      for (int c = 0; c < 4; c++) p1_idx_r[c] <= idx[c];
    end
  end

  // P2: significant bits, unclamped fraction count
  logic               p2_vld_r, p2_dz_r, p2_zero_r;
  logic signed [63:0] p2_q_r;
  logic [6:0]         p2_n_r;
  logic [4:0]         p2_na_r, p2_ma_r;
  logic signed [8:0]  p2_nf_r;
  logic [6:0]         sig;

  always_comb begin
    sig = 7'd1;
    for (int c = 0; c < 4; c++) begin
      if (p1_hit_r[c]) sig = 7'(16*c + 2) + {3'b0, p1_idx_r[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p2_vld_r <= 1'b0;
    else if (adv) p2_vld_r <= p1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_q_r    <= p1_q_r;
      p2_n_r    <= p1_n_r;
      p2_dz_r   <= p1_dz_r;
      p2_na_r   <= p1_na_r;
      p2_ma_r   <= p1_ma_r;
      p2_zero_r <= p1_zero_r;
      p2_nf_r   <= $signed({2'b0, p1_n_r}) - $signed({2'b0, sig}) + 9'(WIDTH);
    end
  end

  // P3: clamp fraction count, derive shift
  logic               p3_vld_r, p3_dz_r, p3_zero_r, p3_ovf_r;
  logic signed [63:0] p3_q_r;
  logic [4:0]         p3_nf_r, p3_na_r, p3_ma_r;
  logic signed [8:0]  p3_sh_r;
  logic [4:0]         nf_c;
  logic               ovf_c;

  always_comb begin
    ovf_c = 1'b0;
    if (p2_nf_r < 9'sd0) begin
      nf_c  = 5'd0;
      ovf_c = 1'b1;
    end else if (p2_nf_r > 9'(WIDTH - 2)) begin
      nf_c = 5'(WIDTH - 2);
    end else begin
      nf_c = p2_nf_r[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p3_vld_r <= 1'b0;
    else if (adv) p3_vld_r <= p2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_q_r    <= p2_q_r;
      p3_dz_r   <= p2_dz_r;
      p3_na_r   <= p2_na_r;
      p3_ma_r   <= p2_ma_r;
      p3_zero_r <= p2_zero_r;
      p3_ovf_r  <= ovf_c;
      p3_nf_r   <= nf_c;
      p3_sh_r   <= $signed({2'b0, p2_n_r}) - $signed({4'b0, nf_c});
    end
  end

  // P4: output register
  logic               o_vld_r, o_dz_r, o_ovf_r;
  logic signed [31:0] o_raw_r;
  logic [4:0]         o_frac_r, o_int_r;
  logic signed [63:0] shv;
  logic [8:0]         nsh;

  always_comb begin
    nsh = 9'(-p3_sh_r);
    if (p3_sh_r > 9'sd0) shv = p3_q_r >>> p3_sh_r[7:0];
    else shv = p3_q_r <<< nsh[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (adv) o_vld_r <= p3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (p3_dz_r) begin
        o_raw_r  <= 32'sd0;
        o_frac_r <= p3_na_r;
        o_int_r  <= p3_ma_r;
        o_dz_r   <= 1'b1;
        o_ovf_r  <= 1'b0;
      end else if (p3_zero_r) begin
        o_raw_r  <= 32'sd0;
        o_frac_r <= 5'(WIDTH - 2);
        o_int_r  <= 5'd1;
        o_dz_r   <= 1'b0;
        o_ovf_r  <= 1'b0;
      end else begin
        o_raw_r  <= sext_w(shv[31:0]);
        o_frac_r <= p3_nf_r;
        o_int_r  <= 5'(WIDTH - 1) - p3_nf_r;
        o_dz_r   <= 1'b0;
        o_ovf_r  <= p3_ovf_r;
      end
    end
  end

  assign out_valid            = o_vld_r;
  assign out_result_raw       = o_raw_r;
  assign out_result_frac_bits = o_frac_r;
  assign out_result_int_bits  = o_int_r;
  assign out_div_by_zero      = o_dz_r;
  assign out_overflow         = o_ovf_r;

  `DFPA_ASSERT_IMP(ast_ovf_frac, out_valid && out_overflow, out_result_frac_bits == 5'd0 && !out_div_by_zero)
  `DFPA_ASSERT_IMP(ast_fmt_sum, out_valid && !out_div_by_zero, out_result_frac_bits + out_result_int_bits == 5'(WIDTH - 1))
  `DFPA_ASSERT_IMP(ast_no_stall, !out_stall, !in_stall)
  `DFPA_ASSERT_NXT(ast_dz_travel, adv && d_vld_r && d_dz_r, p1_vld_r && p1_dz_r)

endmodule

// ----- tb/dfpa_alu_checker.sv -----
// Result checker for the dynamic fixed-point ALU: watches both channels, predicts
// each result and compares it with what leaves the block.
// Depends on dfpa_pkg for the width and operation codes.
`timescale 1ns / 100ps

module dfpa_alu_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_a_raw,
  input  logic [4:0]         in_a_frac_bits,
  input  logic [4:0]         in_a_int_bits,
  input  logic signed [31:0] in_b_raw,
  input  logic [4:0]         in_b_frac_bits,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_result_raw,
  input  logic [4:0]         out_result_frac_bits,
  input  logic [4:0]         out_result_int_bits,
  input  logic               out_div_by_zero,
  input  logic               out_overflow,
  output int                 fail_count,
  output int                 pending
);
  import dfpa_pkg::*;

  typedef struct packed {
    logic signed [31:0] raw;
    logic [4:0]         nf;
    logic [4:0]         ni;
    logic               dz;
    logic               ovf;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic longint to_width(longint q);
    return (q <<< (64 - WIDTH)) >>> (64 - WIDTH);
  endfunction

  // two's complement bits needed, sign included
  function automatic int bits_needed(longint q);
    longint unsigned u;
    int n;
    u = (q >= 0) ? q : ~q;
    n = 1;
    while (u != 0) begin
      u = u >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic longint shr(longint q, int s);
    if (s <= 0) return q;
    if (s >= 64) return (q < 0) ? -64'sd1 : 64'sd0;
    return q >>> s;
  endfunction

  function automatic longint shl(longint q, int s);
    if (s <= 0) return q;
    return q <<< s;
  endfunction

  // align to a new fraction count; left shifts keep at most 62 significant bits
  function automatic longint align(longint q, int from, int to);
    int s;
    int cap;
    s = to - from;
    if (s == 0) return q;
    if (s < 0) return shr(q, -s);
    cap = 62 - (bits_needed(q) - 1);
    if (cap <= 0) return q;
    return shl(q, (s < cap) ? s : cap);
  endfunction

  function automatic alu_result_t renormalise(longint q, int n_in);
    alu_result_t r;
    int sh;
    int nf;
    longint v;
    r = '0;
    if (q == 0) begin
      r.nf = 5'(WIDTH - 2);
      r.ni = 5'd1;
      return r;
    end
    sh = bits_needed(q) - WIDTH;
    nf = n_in - sh;
    if (nf < 0) begin
      sh += nf;
      nf = 0;
      r.ovf = 1'b1;
    end
    if (nf > WIDTH - 2) begin
      sh += nf - (WIDTH - 2);
      nf = WIDTH - 2;
    end
    v = (sh > 0) ? shr(q, sh) : shl(q, -sh);
    r.raw = 32'(to_width(v));
    r.nf  = 5'(nf);
    r.ni  = 5'(WIDTH - 1 - nf);
    return r;
  endfunction

  function automatic alu_result_t alu_predict(logic [1:0] op, logic [31:0] ar, int na,
                                              logic [4:0] ma, logic [31:0] br, int nb);
    alu_result_t r;
    longint a;
    longint b;
    longint qa;
    longint qb;
    int nout;
    int boost;
    a = to_width(longint'($signed(ar)));
    b = to_width(longint'($signed(br)));
    r = '0;
    case (op)
      OP_ADD, OP_SUB: begin
        nout = (na > nb) ? na : nb;
        qa = align(a, na, nout);
        qb = align(b, nb, nout);
        r = renormalise((op == OP_ADD) ? qa + qb : qa - qb, nout);
      end
      OP_MUL: r = renormalise(a * b, na + nb);
      default: begin
        if (b == 0) begin
          r.nf = 5'(na);
          r.ni = ma;
          r.dz = 1'b1;
        end else begin
          boost = 62 - (bits_needed(a) - 1);
          if (boost < 0) boost = 0;
          r = renormalise(shl(a, boost) / b, na + boost - nb);
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t got;
    alu_result_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(alu_predict(in_action, in_a_raw, in_a_frac_bits,
                                               in_a_int_bits, in_b_raw, in_b_frac_bits));
      if (out_valid && !out_stall) begin
        got = '{out_result_raw, out_result_frac_bits, out_result_int_bits,
                out_div_by_zero, out_overflow};
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected result item: raw %0d", got.raw);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"mismatch: want raw %0d nf %0d ni %0d dz %0b ovf %0b, ",
                        "got raw %0d nf %0d ni %0d dz %0b ovf %0b"},
                       want.raw, want.nf, want.ni, want.dz, want.ovf,
                       got.raw, got.nf, got.ni, got.dz, got.ovf);
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ----- tb/tb_dynamic_fixed_point_alu_unit.sv -----
// Top of the ALU testbench: clock, reset, directed and random items, receiver stalls.
// Depends on dfpa_pkg, the ALU top level and dfpa_alu_checker.
`timescale 1ns / 100ps

module tb_dynamic_fixed_point_alu_unit;
  import dfpa_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = OP_ADD;
  logic signed [31:0] in_a_raw = '0;
  logic [4:0]         in_a_frac_bits = '0;
  logic [4:0]         in_a_int_bits = '0;
  logic signed [31:0] in_b_raw = '0;
  logic [4:0]         in_b_frac_bits = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_result_raw;
  logic [4:0]         out_result_frac_bits;
  logic [4:0]         out_result_int_bits;
  logic               out_div_by_zero;
  logic               out_overflow;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 hold_cycles = 0;

  always #1 clk = ~clk;

  dynamic_fixed_point_alu_unit u_top (.*);
  dfpa_alu_checker u_check (.*);

  // receiver: random stalls, or a long counted hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_item(logic [1:0] op, logic [31:0] a, logic [4:0] na, logic [4:0] ma,
                           logic [31:0] b, logic [4:0] nb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_action = op;
    in_a_raw = a;
    in_a_frac_bits = na;
    in_a_int_bits = ma;
    in_b_raw = b;
    in_b_frac_bits = nb;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(200)) - 100);
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  task automatic send_random(int count);
    logic [31:0] b;
    for (int i = 0; i < count; i++) begin
      b = pick_operand();
      if ($urandom_range(19) == 0) b = '0;
      send_item(2'($urandom_range(3)), pick_operand(), 5'($urandom_range(31)),
                5'($urandom_range(31)), b, 5'($urandom_range(31)));
    end
  endtask

  initial begin
    #1000000;
    $display("dynamic_fixed_point_alu_unit regression: fail");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // directed: extremes, every operation, zero result, overflow, divide by zero
    send_item(OP_ADD, 32'h7fffffff, 5'd0, 5'd31, 32'h7fffffff, 5'd0);
    send_item(OP_ADD, 32'h80000000, 5'd31, 5'd0, 32'h80000000, 5'd31);
    send_item(OP_ADD, 32'h00000001, 5'd0, 5'd31, 32'h00000001, 5'd30);
    send_item(OP_SUB, 32'h12345678, 5'd7, 5'd24, 32'h12345678, 5'd7);
    send_item(OP_SUB, 32'h80000000, 5'd0, 5'd31, 32'h7fffffff, 5'd0);
    send_item(OP_SUB, 32'h00000000, 5'd30, 5'd1, 32'hffffffff, 5'd31);
    send_item(OP_MUL, 32'h80000000, 5'd0, 5'd31, 32'h80000000, 5'd0);
    send_item(OP_MUL, 32'h7fffffff, 5'd31, 5'd0, 32'h7fffffff, 5'd31);
    send_item(OP_MUL, 32'hffffffff, 5'd0, 5'd31, 32'h00000001, 5'd0);
    send_item(OP_MUL, 32'h00000000, 5'd5, 5'd26, 32'h7fffffff, 5'd3);
    send_item(OP_DIV, 32'h7fffffff, 5'd31, 5'd17, 32'h00000000, 5'd0);
    send_item(OP_DIV, 32'h80000000, 5'd0, 5'd31, 32'h00000000, 5'd31);
    send_item(OP_DIV, 32'h80000000, 5'd0, 5'd31, 32'hffffffff, 5'd31);
    send_item(OP_DIV, 32'h7fffffff, 5'd0, 5'd31, 32'h00000001, 5'd30);
    send_item(OP_DIV, 32'h00000001, 5'd31, 5'd0, 32'h7fffffff, 5'd0);
    send_item(OP_DIV, 32'h00000000, 5'd4, 5'd27, 32'h00000003, 5'd2);
    send_item(OP_DIV, 32'hfffffff9, 5'd0, 5'd31, 32'h00000002, 5'd0);
    send_item(OP_ADD, 32'hffffffff, 5'd31, 5'd0, 32'h00000001, 5'd31);
    // phase one: sender idles a little, receiver a lot, with one long hold-off
    send_idle_pct = 19;
    recv_idle_pct = 52;
    hold_cycles = 300;
    send_random(183);
    // let everything drain before the next phase
    in_valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
    send_idle_pct = 52;
    recv_idle_pct = 19;
    send_random(183);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(184);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("dynamic_fixed_point_alu_unit regression: pass");
    else
      $display("dynamic_fixed_point_alu_unit regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dfpa_pkg.sv
rtl/dfpa_div_pipe.sv
rtl/dynamic_fixed_point_alu_unit.sv
tb/dfpa_alu_checker.sv
tb/tb_dynamic_fixed_point_alu_unit.sv
